[src/dls_pkg.sv]
// package: shared types, constants and sigmoid table entry function for the dense layer unit
`timescale 1ns / 1ps
package dls_pkg;

  localparam int MAX_INPUTS_DEF      = 64;
  localparam int MAX_OUTPUTS_DEF     = 16;
  localparam int SIGMOID_ENTRIES_DEF = 256;
  localparam int QDEPTH              = 2;

  localparam logic [1:0] CMD_WEIGHT = 2'd0;
  localparam logic [1:0] CMD_BIAS   = 2'd1;
  localparam logic [1:0] CMD_SAMPLE = 2'd2;

  localparam logic       REG_INPUT_COUNT  = 1'b0;
  localparam logic       REG_OUTPUT_COUNT = 1'b1;
  localparam logic [6:0] INPUT_COUNT_RST  = 7'd64;
  localparam logic [4:0] OUTPUT_COUNT_RST = 5'd16;

  typedef enum logic [1:0] {K_WEIGHT, K_BIAS, K_SAMPLE} kind_t;

  typedef struct packed {
    kind_t              kind;
    logic               keep;
    logic [9:0]         slot;
    logic signed [15:0] value;
    logic               start;
  } entry_t;

  typedef enum logic [2:0] {
    B_IDLE, B_BIAS, B_INIT, B_MAC, B_SAT, B_CLAMP, B_IDX, B_OUT
  } bstate_t;

  // shift-subtract quotient of two non-negative values, elaboration only
  function automatic longint udiv(input longint a, input longint b);
    longint q;
    longint r;
    q = 0;
    r = 0;
    for (int n_bit = 62; n_bit >= 0; n_bit--) begin
      r = (r <<< 1) | ((a >>> n_bit) & 64'sd1);
      q = q <<< 1;
      if (r >= b) begin
        r = r - b;
        q = q | 64'sd1;
      end
    end
    return q;
  endfunction

  // one table entry, evaluated at elaboration only
  function automatic logic [15:0] sig_entry(input int k, input int n);
    longint num;
    longint mag;
    longint u;
    longint term;
    longint sum;
    longint e;
    longint den;
    logic   neg;
    num  = longint'(2 * k + 1) * 8 - 8 * longint'(n);
    neg  = (num < 0);
    mag  = neg ? -num : num;
    u    = udiv(mag <<< 26, longint'(n));
    term = 64'sd1 <<< 30;
    sum  = 64'sd1 <<< 30;
    for (int i = 1; i <= 12; i++) begin
      term = udiv((term * u) >>> 30, longint'(i));
      if ((i & 1) == 1) sum = sum - term;
      else              sum = sum + term;
    end
    e = sum;
    for (int i = 0; i < 4; i++) begin
      e = (e * e + (64'sd1 <<< 29)) >>> 30;
    end
    den = (64'sd1 <<< 30) + e;
    if (neg) return 16'(udiv(e * 32768 + (den >>> 1), den));
    return 16'(udiv((64'sd1 <<< 45) + (den >>> 1), den));
  endfunction

endpackage

[src/dls_front.sv]
// front end: config registers, command decode and queue push
`timescale 1ns / 1ps
module dls_front #(
  parameter int MAX_INPUTS  = dls_pkg::MAX_INPUTS_DEF,
  parameter int MAX_OUTPUTS = dls_pkg::MAX_OUTPUTS_DEF,
  localparam int NI_W = $clog2(MAX_INPUTS + 1),
  localparam int NO_W = $clog2(MAX_OUTPUTS + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [1:0]         cmd,
  input  logic [9:0]         slot,
  input  logic signed [15:0] value,
  input  logic               start_req,
  input  logic               cfg_we,
  input  logic               cfg_addr,
  input  logic [6:0]         cfg_data,
  input  logic               q_full,
  output logic               push,
  output dls_pkg::entry_t    entry,
  output logic [NI_W-1:0]    ni,
  output logic [NO_W-1:0]    no
);

  localparam int WDEPTH = MAX_INPUTS * MAX_OUTPUTS;

  logic [6:0] input_count;
  logic [4:0] output_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      input_count  <= dls_pkg::INPUT_COUNT_RST;
      output_count <= dls_pkg::OUTPUT_COUNT_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        dls_pkg::REG_INPUT_COUNT:  input_count  <= cfg_data;
        dls_pkg::REG_OUTPUT_COUNT: output_count <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  assign ni = (32'(input_count) > MAX_INPUTS) ? NI_W'(MAX_INPUTS) : NI_W'(input_count);
  assign no = (32'(output_count) > MAX_OUTPUTS) ? NO_W'(MAX_OUTPUTS) : NO_W'(output_count);

  always_comb begin
    entry.slot  = slot;
    entry.value = value;
    entry.start = 1'b0;
    entry.kind  = dls_pkg::K_SAMPLE;
    entry.keep  = 1'b0;
    push        = 1'b0;
    unique case (cmd)
      dls_pkg::CMD_WEIGHT: begin
        entry.kind = dls_pkg::K_WEIGHT;
        entry.keep = 32'(slot) < WDEPTH;
        push       = start && !q_full;
      end
      dls_pkg::CMD_BIAS: begin
        entry.kind = dls_pkg::K_BIAS;
        entry.keep = 32'(slot) < MAX_OUTPUTS;
        push       = start && !q_full;
      end
      dls_pkg::CMD_SAMPLE: begin
        entry.kind  = dls_pkg::K_SAMPLE;
        entry.keep  = 32'(slot) < MAX_INPUTS;
        entry.start = start_req;
        push        = start && !q_full;
      end
      default: ;
    endcase
  end

endmodule

[src/dls_queue.sv]
// short item queue between front and back
`timescale 1ns / 1ps
module dls_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  dls_pkg::entry_t din,
  input  logic            pop,
  output dls_pkg::entry_t dout,
  output logic            empty,
  output logic            full
);

  localparam int PW = $clog2(dls_pkg::QDEPTH);
  localparam int CW = $clog2(dls_pkg::QDEPTH + 1);

  dls_pkg::entry_t mem [dls_pkg::QDEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign empty = (count == '0);
  assign full  = (count == CW'(dls_pkg::QDEPTH));
  assign dout  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= din;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (32'(wr_ptr) == dls_pkg::QDEPTH - 1) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (32'(rd_ptr) == dls_pkg::QDEPTH - 1) ? '0 : rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (!push && pop) count <= count - 1'b1;
    end
  end

endmodule

[src/dls_back.sv]
// back end: stores, multiply-accumulate, saturation and sigmoid lookup
`timescale 1ns / 1ps
module dls_back #(
  parameter int MAX_INPUTS      = dls_pkg::MAX_INPUTS_DEF,
  parameter int MAX_OUTPUTS     = dls_pkg::MAX_OUTPUTS_DEF,
  parameter int SIGMOID_ENTRIES = dls_pkg::SIGMOID_ENTRIES_DEF,
  localparam int NI_W = $clog2(MAX_INPUTS + 1),
  localparam int NO_W = $clog2(MAX_OUTPUTS + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_empty,
  input  dls_pkg::entry_t    q_data,
  output logic               pop,
  input  logic [NI_W-1:0]    ni,
  input  logic [NO_W-1:0]    no,
  output logic               strobe,
  output logic [3:0]         neuron,
  output logic signed [31:0] weighted_sum,
  output logic [15:0]        activation,
  output logic               final_res
);

  localparam int WDEPTH = MAX_INPUTS * MAX_OUTPUTS;
  localparam int WA_W   = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
  localparam int SA_W   = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
  localparam int BA_W   = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1;
  localparam int IX_W   = $clog2(SIGMOID_ENTRIES);
  localparam int ACC_W  = 33 + $clog2(MAX_INPUTS + 1);

  typedef logic [15:0] tab_t [SIGMOID_ENTRIES];

  function automatic tab_t build_tab();
    tab_t t;
    for (int k = 0; k < SIGMOID_ENTRIES; k++) t[k] = dls_pkg::sig_entry(k, SIGMOID_ENTRIES);
    return t;
  endfunction

  localparam tab_t SIG_TAB = build_tab();

  logic signed [15:0] weight_mem [WDEPTH];
  logic signed [15:0] bias_mem   [MAX_OUTPUTS];
  logic signed [15:0] sample_mem [MAX_INPUTS];

  dls_pkg::bstate_t state, state_next;

  logic [NI_W-1:0]         i;
  logic [NO_W-1:0]         o;
  logic [WA_W-1:0]         waddr;
  logic signed [15:0]      bias_q;
  logic signed [15:0]      sample_q;
  logic signed [15:0]      weight_q;
  logic signed [31:0]      prod;
  logic                    rd_v;
  logic                    p_v;
  logic signed [ACC_W-1:0] acc;
  logic signed [31:0]      sum;
  logic [27:0]             off;
  logic [IX_W-1:0]         idx;
  logic [40:0]             idx_prod;
  logic [12:0]             idx_raw;
  logic                    issue;
  logic                    mac_done;
  logic                    go;
  logic                    last_o;

  assign idx_prod = 41'(off) * 41'(SIGMOID_ENTRIES);
  assign idx_raw  = idx_prod[40:28];
  assign last_o   = (o + 1'b1 == no);

  always_ff @(posedge clk) begin
    if (pop && q_data.keep) begin
      unique case (q_data.kind)
        dls_pkg::K_WEIGHT: weight_mem[WA_W'(q_data.slot)] <= q_data.value;
        dls_pkg::K_BIAS:   bias_mem[BA_W'(q_data.slot)]   <= q_data.value;
        dls_pkg::K_SAMPLE: sample_mem[SA_W'(q_data.slot)] <= q_data.value;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == dls_pkg::B_BIAS) bias_q <= bias_mem[o[BA_W-1:0]];
    if (issue) begin
      sample_q <= sample_mem[i[SA_W-1:0]];
      weight_q <= weight_mem[waddr];
    end
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    issue      = 1'b0;
    go         = 1'b0;
    mac_done   = (i == ni) && !rd_v && !p_v;
    unique case (state)
      dls_pkg::B_IDLE: begin
        if (!q_empty) begin
          pop = 1'b1;
          if (q_data.kind == dls_pkg::K_SAMPLE && q_data.start && no != '0) begin
            go         = 1'b1;
            state_next = dls_pkg::B_BIAS;
          end
        end
      end
      dls_pkg::B_BIAS:  state_next = dls_pkg::B_INIT;
      dls_pkg::B_INIT:  state_next = dls_pkg::B_MAC;
      dls_pkg::B_MAC: begin
        issue = (i != ni);
        if (mac_done) state_next = dls_pkg::B_SAT;
      end
      dls_pkg::B_SAT:   state_next = dls_pkg::B_CLAMP;
      dls_pkg::B_CLAMP: state_next = dls_pkg::B_IDX;
      dls_pkg::B_IDX:   state_next = dls_pkg::B_OUT;
      dls_pkg::B_OUT:   state_next = last_o ? dls_pkg::B_IDLE : dls_pkg::B_BIAS;
      default:          state_next = dls_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= dls_pkg::B_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v      <= 1'b0;
      p_v       <= 1'b0;
      strobe    <= 1'b0;
      final_res <= 1'b0;
      i         <= '0;
      o         <= '0;
      waddr     <= '0;
    end else begin
      rd_v      <= issue;
      p_v       <= rd_v;
      strobe    <= 1'b0;
      final_res <= 1'b0;
      if (go) begin
        o     <= '0;
        waddr <= '0;
      end
      if (state == dls_pkg::B_INIT) i <= '0;
      if (issue) begin
        i     <= i + 1'b1;
        waddr <= waddr + 1'b1;
      end
      if (state == dls_pkg::B_OUT) begin
        strobe    <= 1'b1;
        final_res <= last_o;
        o         <= o + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod <= sample_q * weight_q;
    if (state == dls_pkg::B_INIT) acc <= ACC_W'(bias_q) <<< 12;
    else if (p_v)                 acc <= acc + ACC_W'(prod);
    if (state == dls_pkg::B_SAT) begin
      if (acc[ACC_W-1:31] == '0 || acc[ACC_W-1:31] == '1) sum <= acc[31:0];
      else if (acc[ACC_W-1])                              sum <= 32'sh8000_0000;
      else                                                sum <= 32'sh7fff_ffff;
    end
    if (state == dls_pkg::B_CLAMP) begin
      if (sum[31:27] == 5'b0 || sum[31:27] == 5'b11111) off <= {~sum[27], sum[26:0]};
      else if (sum[31])                                   off <= '0;
      else                                                off <= '1;
    end
    if (state == dls_pkg::B_IDX) begin
      if (32'(idx_raw) >= SIGMOID_ENTRIES) idx <= IX_W'(SIGMOID_ENTRIES - 1);
      else                                 idx <= IX_W'(idx_raw);
    end
    if (state == dls_pkg::B_OUT) begin
      neuron       <= 4'(o);
      weighted_sum <= sum;
      activation   <= SIG_TAB[idx];
    end
  end

endmodule

[src/dense_layer_sigmoid_forward_unit.sv]
// top level: dense layer forward pass with sigmoid activation
// Items (weight, bias or sample loads) are taken whenever busy is low; busy rises only while the
// two-entry item queue is full. The back end writes a load item with an in-range slot into its
// store as it pops it from the queue. A sample item with start_req set, taken while output_count
// is nonzero, starts the forward pass, which walks the stores with one multiplier. Each output
// neuron goes through bias read, accumulator load, one multiply-accumulate issue per input in use
// (input_count saturated to MAX_INPUTS), pipeline drain, then saturation, clamp, table index and
// output. Items queued behind a pass wait for it. One result per neuron appears on the result
// ports, in neuron order, for exactly one cycle with strobe high; the receiver cannot stall and
// results cannot be held off. Configuration writes are taken at once.
`timescale 1ns / 1ps
module dense_layer_sigmoid_forward_unit #(
  parameter int MAX_INPUTS      = dls_pkg::MAX_INPUTS_DEF,
  parameter int MAX_OUTPUTS     = dls_pkg::MAX_OUTPUTS_DEF,
  parameter int SIGMOID_ENTRIES = dls_pkg::SIGMOID_ENTRIES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         cmd,
  input  logic [9:0]         slot,
  input  logic signed [15:0] value,
  input  logic               start_req,
  input  logic               cfg_we,
  input  logic               cfg_addr,
  input  logic [6:0]         cfg_data,
  output logic               strobe,
  output logic [3:0]         neuron,
  output logic signed [31:0] weighted_sum,
  output logic [15:0]        activation,
  output logic               final_res
);

  localparam int NI_W = $clog2(MAX_INPUTS + 1);
  localparam int NO_W = $clog2(MAX_OUTPUTS + 1);

  dls_pkg::entry_t push_entry;
  dls_pkg::entry_t pop_entry;
  logic            push;
  logic            pop;
  logic            q_empty;
  logic            q_full;
  logic [NI_W-1:0] ni;
  logic [NO_W-1:0] no;

  assign busy = q_full;

  dls_front #(.MAX_INPUTS(MAX_INPUTS), .MAX_OUTPUTS(MAX_OUTPUTS)) u_front (
    .clk, .rst, .start, .cmd, .slot, .value, .start_req,
    .cfg_we, .cfg_addr, .cfg_data,
    .q_full, .push, .entry(push_entry), .ni, .no
  );

  dls_queue u_queue (
    .clk, .rst, .push, .din(push_entry), .pop, .dout(pop_entry),
    .empty(q_empty), .full(q_full)
  );

  dls_back #(
    .MAX_INPUTS(MAX_INPUTS), .MAX_OUTPUTS(MAX_OUTPUTS), .SIGMOID_ENTRIES(SIGMOID_ENTRIES)
  ) u_back (
    .clk, .rst, .q_empty, .q_data(pop_entry), .pop, .ni, .no,
    .strobe, .neuron, .weighted_sum, .activation, .final_res
  );

endmodule

[src/dls_checker.sv]
// port-level checker for the dense layer unit, with its bind
`timescale 1ns / 1ps
module dls_checker (
  input logic clk,
  input logic rst,
  input logic busy,
  input logic strobe,
  input logic final_res
);

  a_reset_clear: assert property (@(posedge clk) rst |=> !busy && !strobe)
    else $error("busy or strobe after reset");

  a_final_strobe: assert property (@(posedge clk) disable iff (rst) final_res |-> strobe)
    else $error("final_res without strobe");

  a_strobe_gap: assert property (@(posedge clk) disable iff (rst) strobe |=> !strobe)
    else $error("results in adjacent cycles");

endmodule

bind dense_layer_sigmoid_forward_unit dls_checker u_dls_checker (
  .clk, .rst, .busy, .strobe, .final_res
);

[test/dense_layer_sigmoid_forward_unit_tb.sv]
// testbench: dense layer sigmoid forward unit with a predicting scoreboard and random loads
`timescale 1ns / 1ps
module dense_layer_sigmoid_forward_unit_tb;

  localparam logic [1:0] CMD_NONE = 2'd3;
  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_CYCLES = 16 * (dls_pkg::MAX_INPUTS_DEF + 10) + 40;

  typedef struct {
    logic [3:0]         neuron;
    logic signed [31:0] wsum;
    logic [15:0]        act;
    logic               last;
  } neuron_result_t;

  class layer_scoreboard;
    neuron_result_t     pending[$];
    logic signed [15:0] weights[1024];
    logic signed [15:0] biases[16];
    logic signed [15:0] samples[64];
    bit                 w_ok[1024];
    bit                 b_ok[16];
    bit                 s_ok[64];
    logic [15:0]        sig_lut[256];
    int unsigned        in_count;
    int unsigned        out_count;
    int                 errors;
    int                 results_seen;
    int                 passes;

    function new();
      for (int k = 0; k < 256; k++) sig_lut[k] = sigmoid_point(k);
      in_count = 64;
      out_count = 16;
    endfunction

    function logic [15:0] sigmoid_point(int k);
      longint steps, mag, u, term, acc, e, den;
      bit     neg;
      steps = longint'(16 * k + 8) - 2048;
      neg = steps < 0;
      mag = neg ? -steps : steps;
      u = (mag <<< 26) / 256;
      term = 64'sd1 <<< 30;
      acc = term;
      for (int i = 1; i <= 12; i++) begin
        term = ((term * u) >>> 30) / i;
        acc = (i % 2 == 1) ? acc - term : acc + term;
      end
      e = acc;
      for (int i = 0; i < 4; i++) e = (e * e + (64'sd1 <<< 29)) >>> 30;
      den = (64'sd1 <<< 30) + e;
      if (neg) return 16'((e * 32768 + den / 2) / den);
      return 16'(((64'sd1 <<< 45) + den / 2) / den);
    endfunction

    function int active_inputs();
      return in_count > 64 ? 64 : in_count;
    endfunction

    function int active_outputs();
      return out_count > 16 ? 16 : out_count;
    endfunction

    function void write_reg(logic addr, logic [6:0] data);
      if (addr == dls_pkg::REG_INPUT_COUNT) in_count = data;
      else out_count = data[4:0];
    endfunction

    function void note_item(logic [1:0] c, logic [9:0] s, logic signed [15:0] v, logic r);
      int             ni, no, idx;
      longint         acc, clip;
      neuron_result_t res;
      if (c == dls_pkg::CMD_WEIGHT) begin
        weights[s] = v;
        w_ok[s] = 1;
      end else if (c == dls_pkg::CMD_BIAS) begin
        if (s < 16) begin
          biases[s] = v;
          b_ok[s] = 1;
        end
      end else if (c == dls_pkg::CMD_SAMPLE) begin
        if (s < 64) begin
          samples[s] = v;
          s_ok[s] = 1;
        end
        if (r) begin
          ni = active_inputs();
          no = active_outputs();
          passes++;
          for (int o = 0; o < no; o++) begin
            acc = longint'(biases[o]) * 4096;
            for (int i = 0; i < ni; i++)
              acc += longint'(samples[i]) * longint'(weights[o * ni + i]);
            if (acc > 64'sd2147483647) acc = 64'sd2147483647;
            if (acc < -64'sd2147483648) acc = -64'sd2147483648;
            clip = acc;
            if (clip > (64'sd1 <<< 27) - 1) clip = (64'sd1 <<< 27) - 1;
            if (clip < -(64'sd1 <<< 27)) clip = -(64'sd1 <<< 27);
            idx = int'(((clip + (64'sd1 <<< 27)) * 256) >>> 28);
            if (idx > 255) idx = 255;
            res.neuron = o[3:0];
            res.wsum = acc[31:0];
            res.act = sig_lut[idx];
            res.last = (o == no - 1);
            pending.push_back(res);
          end
        end
      end
    endfunction

    function void check_result(logic [3:0] n, logic signed [31:0] ws, logic [15:0] a,
                               logic f);
      neuron_result_t exp_res;
      results_seen++;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result: neuron %0d sum %0d", n, ws);
        return;
      end
      exp_res = pending.pop_front();
      if (n !== exp_res.neuron || ws !== exp_res.wsum || a !== exp_res.act ||
          f !== exp_res.last) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp n=%0d sum=%0d act=%0d last=%0b %s%0d %s%0d %s%0d %s%0b",
                   exp_res.neuron, exp_res.wsum, exp_res.act, exp_res.last,
                   "got n=", n, "sum=", ws, "act=", a, "last=", f);
      end
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic [1:0]         cmd;
  logic [9:0]         slot;
  logic signed [15:0] value;
  logic               start_req;
  logic               cfg_we;
  logic               cfg_addr;
  logic [6:0]         cfg_data;
  logic               strobe;
  logic [3:0]         neuron;
  logic signed [31:0] weighted_sum;
  logic [15:0]        activation;
  logic               final_res;

  layer_scoreboard sb;
  int              idle_pct;
  int              items_sent;
  int              cycles;

  dense_layer_sigmoid_forward_unit u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd), .slot(slot),
    .value(value), .start_req(start_req), .cfg_we(cfg_we), .cfg_addr(cfg_addr),
    .cfg_data(cfg_data), .strobe(strobe), .neuron(neuron), .weighted_sum(weighted_sum),
    .activation(activation), .final_res(final_res)
  );

  initial clk = 0;
  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && strobe) sb.check_result(neuron, weighted_sum, activation, final_res);
  end

  task automatic send_item(logic [1:0] c, logic [9:0] s, logic signed [15:0] v, logic r);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 0;
      @(posedge clk);
    end
    start <= 1;
    cmd <= c;
    slot <= s;
    value <= v;
    start_req <= r;
    do @(posedge clk); while (busy);
    sb.note_item(c, s, v, r);
    items_sent++;
  endtask

  task automatic settle();
    start <= 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic addr, logic [6:0] data);
    cfg_we <= 1;
    cfg_addr <= addr;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 0;
    sb.write_reg(addr, data);
    @(posedge clk);
  endtask

  // make sure every entry the next pass reads has been written
  task automatic fill_needed(bit rnd, logic signed [15:0] v);
    int ni, no;
    ni = sb.active_inputs();
    no = sb.active_outputs();
    for (int i = 0; i < ni; i++)
      if (!sb.s_ok[i])
        send_item(dls_pkg::CMD_SAMPLE, 10'(i), rnd ? 16'($urandom) : v, 0);
    for (int o = 0; o < no; o++)
      if (!sb.b_ok[o])
        send_item(dls_pkg::CMD_BIAS, 10'(o), rnd ? 16'($urandom) : v, 0);
    for (int w = 0; w < ni * no; w++)
      if (!sb.w_ok[w])
        send_item(dls_pkg::CMD_WEIGHT, 10'(w), rnd ? 16'($urandom) : v, 0);
  endtask

  task automatic random_items(int count);
    int ni, no, pick;
    ni = sb.active_inputs();
    no = sb.active_outputs();
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        fill_needed(1, 0);
        send_item(dls_pkg::CMD_SAMPLE, (ni > 0) ? 10'($urandom_range(0, ni - 1)) : 10'd0,
                  16'($urandom), 1);
      end else if (pick < 70) begin
        case ($urandom_range(0, 2))
          0: if (ni * no > 0) send_item(dls_pkg::CMD_WEIGHT,
                                        10'($urandom_range(0, ni * no - 1)),
                                        16'($urandom), 0);
          1: if (no > 0) send_item(dls_pkg::CMD_BIAS, 10'($urandom_range(0, no - 1)),
                                   16'($urandom), 0);
          default: if (ni > 0) send_item(dls_pkg::CMD_SAMPLE,
                                         10'($urandom_range(0, ni - 1)),
                                         16'($urandom), 0);
        endcase
      end else begin
        // noise: any command, any slot, stray start flags
        logic [1:0] c;
        logic       r;
        c = 2'($urandom);
        r = 1'($urandom);
        if (c == dls_pkg::CMD_SAMPLE && r) fill_needed(1, 0);
        send_item(c, 10'($urandom), 16'($urandom), r);
      end
    end
    fill_needed(1, 0);
    send_item(dls_pkg::CMD_SAMPLE, 10'($urandom), 16'($urandom), 1);
  endtask

  task automatic run_phase(logic [6:0] ins, logic [6:0] outs, int count);
    write_reg(dls_pkg::REG_INPUT_COUNT, ins);
    write_reg(dls_pkg::REG_OUTPUT_COUNT, outs);
    random_items(count);
    settle();
  endtask

  initial begin
    sb = new();
    idle_pct = 33;
    items_sent = 0;
    rst <= 1;
    start <= 0;
    cmd <= dls_pkg::CMD_WEIGHT;
    slot <= 0;
    value <= 0;
    start_req <= 0;
    cfg_we <= 0;
    cfg_addr <= dls_pkg::REG_INPUT_COUNT;
    cfg_data <= 0;
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    write_reg(dls_pkg::REG_INPUT_COUNT, 7'd3);
    write_reg(dls_pkg::REG_OUTPUT_COUNT, 7'd2);
    send_item(dls_pkg::CMD_WEIGHT, 0, 16'sh7fff, 0);
    send_item(dls_pkg::CMD_WEIGHT, 1, -16'sh8000, 0);
    send_item(dls_pkg::CMD_WEIGHT, 2, 16'sd1, 0);
    send_item(dls_pkg::CMD_WEIGHT, 3, -16'sd1, 0);
    send_item(dls_pkg::CMD_WEIGHT, 4, 16'sd0, 0);
    send_item(dls_pkg::CMD_WEIGHT, 5, 16'sh7fff, 0);
    send_item(dls_pkg::CMD_BIAS, 0, 16'sh7fff, 1);
    send_item(dls_pkg::CMD_BIAS, 1, -16'sh8000, 0);
    send_item(dls_pkg::CMD_BIAS, 20, 16'sd77, 0);
    send_item(dls_pkg::CMD_WEIGHT, 1023, -16'sd5, 1);
    send_item(CMD_NONE, 10'h3ff, 16'hffff, 1);
    send_item(dls_pkg::CMD_SAMPLE, 0, 16'sh7fff, 0);
    send_item(dls_pkg::CMD_SAMPLE, 1, -16'sh8000, 0);
    send_item(dls_pkg::CMD_SAMPLE, 100, 16'sd9, 0);
    send_item(dls_pkg::CMD_SAMPLE, 2, 16'sd4096, 1);
    send_item(dls_pkg::CMD_SAMPLE, 1000, 16'sd3, 1);
    settle();

    // saturation both ways
    write_reg(dls_pkg::REG_INPUT_COUNT, 7'd4);
    write_reg(dls_pkg::REG_OUTPUT_COUNT, 7'd1);
    fill_needed(0, -16'sh8000);
    for (int i = 0; i < 4; i++) send_item(dls_pkg::CMD_SAMPLE, 10'(i), -16'sh8000, 0);
    for (int i = 0; i < 4; i++) send_item(dls_pkg::CMD_WEIGHT, 10'(i), -16'sh8000, 0);
    send_item(dls_pkg::CMD_BIAS, 0, -16'sh8000, 0);
    send_item(dls_pkg::CMD_SAMPLE, 3, -16'sh8000, 1);
    for (int i = 0; i < 4; i++) send_item(dls_pkg::CMD_SAMPLE, 10'(i), 16'sh7fff, i == 3);
    settle();

    run_phase(7'd127, 7'd1, 30);
    run_phase(7'd1, 7'd1, 30);
    run_phase(7'd0, 7'd5, 25);
    idle_pct = 86;
    run_phase(7'd2, 7'd31, 30);
    run_phase(7'd9, 7'd0, 25);
    idle_pct = 0;
    run_phase(7'd12, 7'd4, 30);
    run_phase(7'd5, 7'd7, 30);

    $display("covered %0d items, %0d forward passes, %0d neuron results checked",
             items_sent, sb.passes, sb.results_seen);
    if (sb.pending.size() != 0) begin
      sb.errors += sb.pending.size();
      $display("%0d results never arrived", sb.pending.size());
    end
    $display("%0d mismatches or missing results", sb.errors);
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
